### rtl/core/calendar_date_counter_macros.svh
// Assertion macros shared by the calendar date counter RTL.
`ifndef CALENDAR_DATE_COUNTER_MACROS_SVH
`define CALENDAR_DATE_COUNTER_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define CDC_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("calendar date counter check failed");

// The condition must hold in the cycle after the trigger.
`define CDC_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("calendar date counter check failed");

`endif

### rtl/core/cdc_pkg.sv
// Types, codes and calendar constants shared by the calendar date counter.
package cdc_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 16;
    localparam int COUNT_W = 16;
    localparam int ACT_W   = 2;

    localparam logic [ACT_W-1:0] ACT_SET  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INC  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ADD  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LEAP_FEB = 5'd29;

    // Multiplicative inverse of 25 modulo 2**16, and the largest quotient
    // 65535 / 25. A 16-bit value is a multiple of 25 exactly when its
    // product with the inverse, kept to 16 bits, is at most that quotient.
    localparam logic [YEAR_W-1:0] INV25_MOD16 = 16'd23593;
    localparam logic [YEAR_W-1:0] DIV25_LIMIT = 16'd2621;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET_LEAP,
        ST_SET_CLAMP,
        ST_RUN,
        ST_PUBLISH
    } state_t;

    typedef struct packed {
        logic load;     // latch the accepted item
        logic clamp;    // clamp the loaded day to the month length
        logic step;     // advance the date by one day
        logic publish;  // copy the date to the output register
    } cmd_t;

    typedef struct packed {
        logic count_zero;
    } status_t;

    // Days in a month held in 1..12; leap selects 29 days for February.
    function automatic logic [DAY_W-1:0] month_days(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [DAY_W-1:0] days;
        case (month)
            4'd2:                      days = leap ? DAY_LEAP_FEB : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
            default:                   days = 5'd31;
        endcase
        return days;
    endfunction

endpackage

### rtl/core/cdc_ctrl.sv
// Controller state machine of the calendar date counter.
module cdc_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            action,
    input  cdc_pkg::status_t      status,
    input  logic                  out_ready,
    output logic                  out_valid,
    output cdc_pkg::cmd_t         cmd
);

    cdc_pkg::state_t state_reg;
    cdc_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cdc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (action == cdc_pkg::ACT_SET) ?
                                 cdc_pkg::ST_SET_LEAP : cdc_pkg::ST_RUN;
                end
            end
            cdc_pkg::ST_SET_LEAP:  state_next = cdc_pkg::ST_SET_CLAMP;
            cdc_pkg::ST_SET_CLAMP: state_next = cdc_pkg::ST_PUBLISH;
            cdc_pkg::ST_RUN:
            begin
                if (status.count_zero)
                begin
                    state_next = cdc_pkg::ST_PUBLISH;
                end
            end
            cdc_pkg::ST_PUBLISH:
            begin
                if (out_free)
                begin
                    state_next = cdc_pkg::ST_IDLE;
                end
            end
            default: state_next = cdc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            cdc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            cdc_pkg::ST_SET_LEAP:  cmd = '0;
            cdc_pkg::ST_SET_CLAMP: cmd.clamp = 1'b1;
            cdc_pkg::ST_RUN:       cmd.step = !status.count_zero;
            cdc_pkg::ST_PUBLISH:   cmd.publish = out_free;
            default:               cmd = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cdc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/core/cdc_datapath.sv
// Datapath of the calendar date counter: date registers, leap flag and day counter.
module cdc_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  cdc_pkg::cmd_t                     cmd,
    output cdc_pkg::status_t                  status,
    input  logic [cdc_pkg::ACT_W-1:0]         action,
    input  logic [cdc_pkg::DAY_W-1:0]         day_in,
    input  logic [cdc_pkg::MONTH_W-1:0]       month_in,
    input  logic [cdc_pkg::YEAR_W-1:0]        year_in,
    input  logic [cdc_pkg::COUNT_W-1:0]       day_count,
    output logic [cdc_pkg::DAY_W-1:0]         day_out,
    output logic [cdc_pkg::MONTH_W-1:0]       month_out,
    output logic [cdc_pkg::YEAR_W-1:0]        year_out
);

    logic [cdc_pkg::DAY_W-1:0]   day_reg,   day_next;
    logic [cdc_pkg::MONTH_W-1:0] month_reg, month_next;
    logic [cdc_pkg::YEAR_W-1:0]  year_reg,  year_next;
    logic [cdc_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                        leap_reg,  leap_next;
    logic [cdc_pkg::DAY_W-1:0]   day_out_reg;
    logic [cdc_pkg::MONTH_W-1:0] month_out_reg;
    logic [cdc_pkg::YEAR_W-1:0]  year_out_reg;

    logic [cdc_pkg::YEAR_W-1:0]   div25_prod;
    logic                         div25;
    logic [cdc_pkg::DAY_W-1:0]    day_max;
    logic [cdc_pkg::MONTH_W-1:0]  month_clamped;

    // Leap test on the held year; registered so that it is ready in the cycle
    // after the year changes.
    assign div25_prod = year_reg * cdc_pkg::INV25_MOD16;
    assign div25      = (div25_prod <= cdc_pkg::DIV25_LIMIT);
    assign leap_next  = div25 ? (year_reg[3:0] == 4'd0) : (year_reg[1:0] == 2'd0);

    assign day_max = cdc_pkg::month_days(month_reg, leap_reg);

    always_comb
    begin
        if (month_in == '0)
        begin
            month_clamped = cdc_pkg::MONTH_JAN;
        end
        else if (month_in > cdc_pkg::MONTH_DEC)
        begin
            month_clamped = cdc_pkg::MONTH_DEC;
        end
        else
        begin
            month_clamped = month_in;
        end
    end

    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        count_next = count_reg;
        if (cmd.load)
        begin
            unique case (action)
                cdc_pkg::ACT_SET:
                begin
                    day_next   = day_in;
                    month_next = month_clamped;
                    year_next  = year_in;
                    count_next = '0;
                end
                cdc_pkg::ACT_INC: count_next = {{(cdc_pkg::COUNT_W-1){1'b0}}, 1'b1};
                cdc_pkg::ACT_ADD: count_next = day_count;
                default:          count_next = '0;
            endcase
        end
        else if (cmd.clamp)
        begin
            if (day_reg == '0)
            begin
                day_next = cdc_pkg::DAY_FIRST;
            end
            else if (day_reg > day_max)
            begin
                day_next = day_max;
            end
        end
        else if (cmd.step)
        begin
            count_next = count_reg - 1'b1;
            if (day_reg >= day_max)
            begin
                day_next = cdc_pkg::DAY_FIRST;
                if (month_reg == cdc_pkg::MONTH_DEC)
                begin
                    month_next = cdc_pkg::MONTH_JAN;
                    year_next  = year_reg + 1'b1;
                end
                else
                begin
                    month_next = month_reg + 1'b1;
                end
            end
            else
            begin
                day_next = day_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_reg   <= cdc_pkg::DAY_FIRST;
            month_reg <= cdc_pkg::MONTH_JAN;
            year_reg  <= '0;
            count_reg <= '0;
            leap_reg  <= 1'b1;
        end
        else
        begin
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            count_reg <= count_next;
            leap_reg  <= leap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            day_out_reg   <= day_reg;
            month_out_reg <= month_reg;
            year_out_reg  <= year_reg;
        end
    end

    assign status.count_zero = (count_reg == '0);
    assign day_out   = day_out_reg;
    assign month_out = month_out_reg;
    assign year_out  = year_out_reg;

endmodule

### rtl/core/calendar_date_counter.sv
// Top level of the calendar date counter: stream ports, controller and datapath.
//
//  Channel   Direction  Payload
//  s_axis    in         tuser: action; tdata: day_in, month_in, year_in, day_count
//  m_axis    out        tdata: day_out, month_out, year_out
//
// Each item begins with the accepting cycle: set loads there, then passes leap
// flag, day clamp and publish; increment, add and unused action run counted
// steps one day per cycle until the count is seen at zero, and then publish.
// The next item is accepted once the result sits in the output register, so a
// stalled consumer holds the publish step only while an older result is untaken.
// Reset sets the date to 1 January of year 0.
`include "calendar_date_counter_macros.svh"

module calendar_date_counter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    input  logic [47:0] s_axis_tdata,   // [4:0] day_in, [8:5] month_in,
                                        // [24:9] year_in, [40:25] day_count, rest zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [4:0] day_out, [8:5] month_out,
                                        // [24:9] year_out, rest zero
);

    cdc_pkg::cmd_t    cmd;
    cdc_pkg::status_t status;

    logic [cdc_pkg::DAY_W-1:0]   day_out;
    logic [cdc_pkg::MONTH_W-1:0] month_out;
    logic [cdc_pkg::YEAR_W-1:0]  year_out;

    // The controller sequences each item; the datapath holds the date.
    cdc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .action    (s_axis_tuser),
        .status    (status),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .cmd       (cmd)
    );

    cdc_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .action    (s_axis_tuser),
        .day_in    (s_axis_tdata[4:0]),
        .month_in  (s_axis_tdata[8:5]),
        .year_in   (s_axis_tdata[24:9]),
        .day_count (s_axis_tdata[40:25]),
        .day_out   (day_out),
        .month_out (month_out),
        .year_out  (year_out)
    );

    // Results are packed with the day in the lowest bits.
    assign m_axis_tdata = {7'd0, year_out, month_out, day_out};

    // A shown result always carries a real calendar day and month.
    `CDC_ASSERT_SAME(a_out_date_range, m_axis_tvalid,
        (day_out != 5'd0) && (month_out != 4'd0) && (month_out <= cdc_pkg::MONTH_DEC))

    // Only one item is in work: the input is closed in the cycle after acceptance.
    `CDC_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // Publishing always leaves a valid result on the output.
    `CDC_ASSERT_NEXT(a_publish_valid, cmd.publish, m_axis_tvalid)

endmodule
